>>> hw/rtl/dtcn_pkg.sv
`default_nettype none

package dtcn_pkg;

  localparam logic [5:0] MONTHS_PER_YEAR = 6'd12;
  localparam logic [5:0] SEC_PER_MIN     = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR    = 6'd60;
  localparam logic [5:0] HOURS_PER_DAY   = 6'd24;
  localparam logic [3:0] MONTH_JAN       = 4'd1;
  localparam logic [3:0] MONTH_FEB       = 4'd2;
  localparam logic [3:0] MONTH_DEC       = 4'd12;

  // floor(y / 100) = (y * CENT_RECIP) >> CENT_SHIFT, exact for y below 2^15
  localparam logic [12:0] CENT_RECIP = 13'd5243;
  localparam int          CENT_SHIFT = 19;
  localparam logic [6:0]  CENTURY    = 7'd100;

  // leap flags for the carried year and for the year after it
  typedef struct packed {
    logic cur;
    logic nxt;
  } dtcn_leap_t;

  function automatic logic [4:0] dtcn_days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dtcn_day_carry.sv
`default_nettype none

module dtcn_day_carry
  import dtcn_pkg::*;
(
  input  wire logic [14:0] year,
  input  wire logic [3:0]  month,
  input  wire logic [6:0]  day,
  input  wire dtcn_leap_t  leap,
  output logic      [13:0] norm_year,
  output logic      [3:0]  norm_month,
  output logic      [4:0]  norm_day
);

  // at most 73 days against months of 28 or more: three month steps suffice
  always_comb begin
    logic [6:0] d;
    logic [3:0] m;
    logic       wrapped;
    logic [4:0] lim;
    d       = day;
    m       = month;
    wrapped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lim = dtcn_days_in(m, wrapped ? leap.nxt : leap.cur);
      if (d > {2'b00, lim}) begin
        d = d - {2'b00, lim};
        if (m == MONTH_DEC) begin
          m       = MONTH_JAN;
          wrapped = 1'b1;
        end else begin
          m = m + 4'd1;
        end
      end
    end
    norm_year  = 14'(year + {14'd0, wrapped});
    norm_month = m;
    norm_day   = d[4:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/datetime_carry_normalizer_unit.sv
`default_nettype none

// Gregorian date and time normaliser.
// s_* channel: one raw timestamp per transaction, s_tdata packed from bit 0:
//   raw_year[13:0], raw_month[5:0], raw_day[5:0], raw_hour, raw_minute, raw_second.
// m_* channel: one normalised timestamp per input transaction, m_tdata from bit 0:
//   norm_year[13:0], norm_month[3:0], norm_day[4:0], norm_hour[4:0],
//   norm_minute[5:0], norm_second[5:0].
// Four register stages: month carry and seconds; minutes and the century
// multiplies for the leap test; hours and leap flags; the day-into-month
// carry feeding the output register. While the receiver does not stall
// the output, one transaction is taken every cycle.
// The stages move together on one enable; when the receiver holds m_tready
// low with a result waiting, the whole pipe freezes and s_tready drops, so
// nothing is lost or repeated. Results leave in input order.
// A synchronous rst clears all valid bits; the pipe is empty afterwards.
module datetime_carry_normalizer_unit
  import dtcn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // raw_year[13:0], raw_month[19:14], raw_day[25:20], raw_hour[33:26],
  // raw_minute[41:34], raw_second[49:42], zero fill [55:50]
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // norm_year[13:0], norm_month[17:14], norm_day[22:18], norm_hour[27:23],
  // norm_minute[33:28], norm_second[39:34]
  output logic      [39:0] m_tdata
);

  // quotient by a small constant through independent threshold compares
  function automatic logic [3:0] div_small(input logic [8:0] v, input logic [5:0] d);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if ({1'b0, v} >= 10'(k) * {4'd0, d}) q = q + 4'd1;
    end
    return q;
  endfunction

  function automatic logic [8:0] rem_small(input logic [8:0] v, input logic [3:0] q,
                                           input logic [5:0] d);
    logic [8:0] p;
    p = {5'd0, q} * {3'd0, d};
    return v - p;
  endfunction

  logic adv;

  // stage 1
  logic        v1;
  logic [14:0] y1;
  logic [3:0]  mon1;
  logic [5:0]  day1;
  logic [7:0]  hr1;
  logic [8:0]  mn1;
  logic [5:0]  sc1;

  // stage 2
  logic        v2;
  logic [14:0] y2;
  logic [8:0]  cq2_cur;
  logic [8:0]  cq2_nxt;
  logic [3:0]  mon2;
  logic [5:0]  day2;
  logic [8:0]  hr2;
  logic [5:0]  mn2;
  logic [5:0]  sc2;

  // stage 3
  logic        v3;
  logic [14:0] y3;
  dtcn_leap_t  leap3;
  logic [3:0]  mon3;
  logic [6:0]  day3;
  logic [4:0]  hr3;
  logic [5:0]  mn3;
  logic [5:0]  sc3;

  // output stage
  logic        v4;
  logic [13:0] year4;
  logic [3:0]  mon4;
  logic [4:0]  day4;
  logic [4:0]  hr4;
  logic [5:0]  mn4;
  logic [5:0]  sc4;

  assign adv      = !v4 || m_tready;
  assign s_tready = adv;

  // stage 1 logic
  logic [13:0] in_year;
  logic [5:0]  in_month, in_day;
  logic [7:0]  in_hour, in_minute, in_second;
  logic [5:0]  mon_c, day_c, mon_r;
  logic [2:0]  yadd;
  logic [3:0]  sc_q;
  logic [8:0]  sc_r;

  assign in_year   = s_tdata[13:0];
  assign in_month  = s_tdata[19:14];
  assign in_day    = s_tdata[25:20];
  assign in_hour   = s_tdata[33:26];
  assign in_minute = s_tdata[41:34];
  assign in_second = s_tdata[49:42];

  always_comb begin
    mon_c = (in_month == 6'd0) ? 6'd1 : in_month;
    day_c = (in_day == 6'd0) ? 6'd1 : in_day;
    yadd  = 3'd0;
    for (int k = 1; k <= 5; k++) begin
      if ({2'b00, mon_c} > 8'(k) * {2'b00, MONTHS_PER_YEAR}) yadd = yadd + 3'd1;
    end
    mon_r = mon_c - 6'({3'd0, yadd} * MONTHS_PER_YEAR);
    sc_q  = div_small({1'b0, in_second}, SEC_PER_MIN);
    sc_r  = rem_small({1'b0, in_second}, sc_q, SEC_PER_MIN);
  end

  // stage 2 logic
  logic [3:0]  mn_q;
  logic [8:0]  mn_r;
  logic [14:0] y1p;
  logic [27:0] prod_cur, prod_nxt;

  always_comb begin
    mn_q     = div_small(mn1, MIN_PER_HOUR);
    mn_r     = rem_small(mn1, mn_q, MIN_PER_HOUR);
    y1p      = y1 + 15'd1;
    prod_cur = {13'd0, y1} * {15'd0, CENT_RECIP};
    prod_nxt = {13'd0, y1p} * {15'd0, CENT_RECIP};
  end

  // stage 3 logic
  logic [3:0]  hr_q;
  logic [8:0]  hr_r;
  logic [14:0] y2p;
  logic [14:0] crem_cur, crem_nxt;
  dtcn_leap_t  leap_c;

  always_comb begin
    hr_q     = div_small(hr2, HOURS_PER_DAY);
    hr_r     = rem_small(hr2, hr_q, HOURS_PER_DAY);
    y2p      = y2 + 15'd1;
    crem_cur = y2 - 15'({7'd0, cq2_cur} * {9'd0, CENTURY});
    crem_nxt = y2p - 15'({7'd0, cq2_nxt} * {9'd0, CENTURY});
    // divisible by 4, and not a century unless the century count is a multiple of 4
    leap_c.cur = (y2[1:0] == 2'b00) && ((crem_cur != 15'd0) || (cq2_cur[1:0] == 2'b00));
    leap_c.nxt = (y2p[1:0] == 2'b00) && ((crem_nxt != 15'd0) || (cq2_nxt[1:0] == 2'b00));
  end

  // stage 4 logic
  logic [13:0] dc_year;
  logic [3:0]  dc_month;
  logic [4:0]  dc_day;

  dtcn_day_carry u_day_carry (
    .year       (y3),
    .month      (mon3),
    .day        (day3),
    .leap       (leap3),
    .norm_year  (dc_year),
    .norm_month (dc_month),
    .norm_day   (dc_day)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1      <= {1'b0, in_year} + {12'd0, yadd};
      mon1    <= mon_r[3:0];
      day1    <= day_c;
      hr1     <= in_hour;
      mn1     <= {1'b0, in_minute} + {5'd0, sc_q};
      sc1     <= sc_r[5:0];

      y2      <= y1;
      cq2_cur <= prod_cur[CENT_SHIFT +: 9];
      cq2_nxt <= prod_nxt[CENT_SHIFT +: 9];
      mon2    <= mon1;
      day2    <= day1;
      hr2     <= {1'b0, hr1} + {5'd0, mn_q};
      mn2     <= mn_r[5:0];
      sc2     <= sc1;

      y3      <= y2;
      leap3   <= leap_c;
      mon3    <= mon2;
      day3    <= {1'b0, day2} + {3'd0, hr_q};
      hr3     <= hr_r[4:0];
      mn3     <= mn2;
      sc3     <= sc2;

      year4   <= dc_year;
      mon4    <= dc_month;
      day4    <= dc_day;
      hr4     <= hr3;
      mn4     <= mn3;
      sc4     <= sc3;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = {sc4, mn4, hr4, day4, mon4, year4};

endmodule

`default_nettype wire

>>> hw/rtl/dtcn_checker.sv
`default_nettype none

module dtcn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [55:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  // a stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // input side only backs up when a result is stuck
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output stall");

  // every delivered timestamp has month 1 to 12, a nonzero day, and hour, minute and second in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= 4'd12)
                 && (m_tdata[22:18] != 5'd0) && (m_tdata[27:23] <= 5'd23)
                 && (m_tdata[33:28] <= 6'd59) && (m_tdata[39:34] <= 6'd59))
    else $error("result out of range");

  // pipe is empty after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

bind datetime_carry_normalizer_unit dtcn_checker u_dtcn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/datetime_stamp_checker.sv
module datetime_stamp_checker
  import dtcn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // raw_year, raw_month, raw_day, raw_hour, raw_minute, raw_second, zero fill
  input  logic [55:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // norm_year, norm_month, norm_day, norm_hour, norm_minute, norm_second
  input  logic [39:0] m_tdata,
  output int          fail_count,
  output int          n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  second;
    logic [7:0]  minute;
    logic [7:0]  hour;
    logic [5:0]  day;
    logic [5:0]  month;
    logic [13:0] year;
  } raw_stamp_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } norm_stamp_t;

  norm_stamp_t norm_q[$];
  int          errors = 0;
  int          n_results = 0;

  function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
    bit leap;
    leap = (yr % 4 == 0) && ((yr % CENTURY != 0) || (yr % 400 == 0));
    case (mo)
      MONTH_FEB:        return leap ? 29 : 28;
      4, 6, 9, 11:      return 30;
      default:          return 31;
    endcase
  endfunction

  function automatic norm_stamp_t normalize_stamp(input raw_stamp_t r);
    int unsigned yr, mo, dy, hr, mi, se, lim;
    norm_stamp_t n;
    yr = r.year;
    mo = r.month;
    dy = r.day;
    hr = r.hour;
    mi = r.minute;
    se = r.second;
    if (mo == 0) mo = 1;
    if (dy == 0) dy = 1;
    while (mo > MONTHS_PER_YEAR) begin
      yr += 1;
      mo -= MONTHS_PER_YEAR;
    end
    mi += se / SEC_PER_MIN;
    se  = se % SEC_PER_MIN;
    hr += mi / MIN_PER_HOUR;
    mi  = mi % MIN_PER_HOUR;
    dy += hr / HOURS_PER_DAY;
    hr  = hr % HOURS_PER_DAY;
    // leap test runs on the full carried year, wrapping only at the output
    lim = month_length(mo, yr);
    while (dy > lim) begin
      dy -= lim;
      mo += 1;
      if (mo > MONTH_DEC) begin
        mo = MONTH_JAN;
        yr += 1;
      end
      lim = month_length(mo, yr);
    end
    n.year   = 14'(yr);
    n.month  = 4'(mo);
    n.day    = 5'(dy);
    n.hour   = 5'(hr);
    n.minute = 6'(mi);
    n.second = 6'(se);
    return n;
  endfunction

  always @(posedge clk) begin
    norm_stamp_t want, got;
    if (!rst) begin
      // pop before push: a result never belongs to a transaction on the same edge
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (norm_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result %0d: %0d-%0d-%0d %0d:%0d:%0d", n_results,
                     got.year, got.month, got.day, got.hour, got.minute, got.second);
          errors++;
        end else begin
          want = norm_q.pop_front();
          if (got.year !== want.year || got.month !== want.month ||
              got.day !== want.day || got.hour !== want.hour ||
              got.minute !== want.minute || got.second !== want.second) begin
            if (errors < 10)
              $display({"mismatch at result %0d: expected %0d-%0d-%0d %0d:%0d:%0d, ",
                        "got %0d-%0d-%0d %0d:%0d:%0d"},
                       n_results,
                       want.year, want.month, want.day, want.hour, want.minute, want.second,
                       got.year, got.month, got.day, got.hour, got.minute, got.second);
            errors++;
          end
        end
        n_results++;
      end
      if (s_tvalid && s_tready)
        norm_q.push_back(normalize_stamp(raw_stamp_t'(s_tdata)));
    end
    fail_count <= errors;
    n_pending  <= norm_q.size();
  end

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  int          fail_count;
  int          n_pending;

  int          n_sent = 0;
  int          n_taken = 0;

  localparam int N_RANDOM    = 1330;
  localparam int HOLD_AT     = 320;
  localparam int HOLD_CYCLES = 80;

  datetime_carry_normalizer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  datetime_stamp_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .n_pending  (n_pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("datetime_carry_normalizer_unit test failed");
    $finish;
  end

  // one raw timestamp per transaction; gap-free stretches every third block of 100
  task automatic send_stamp(input int unsigned yr, input int unsigned mo,
                            input int unsigned dy, input int unsigned hr,
                            input int unsigned mi, input int unsigned se);
    int gap;
    gap = ((n_sent / 100) % 3 == 1) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, se[7:0], mi[7:0], hr[7:0], dy[5:0], mo[5:0], yr[13:0]};
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  // receiver: random stall per result, gap-free stretches, and one long hold-off
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (n_taken == HOLD_AT)
        stall = HOLD_CYCLES;
      else if ((n_taken / 130) % 3 == 2)
        stall = 0;
      else
        stall = $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      n_taken++;
    end
  end

  initial begin
    int unsigned yr, mo, dy, hr, mi, se;
    int          kind;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_stamp(0, 0, 0, 0, 0, 0);               // month zero and day zero
    send_stamp(16383, 63, 63, 255, 255, 255);   // every field at its maximum
    send_stamp(2000, 2, 28, 23, 59, 60);        // second ripples into leap day
    send_stamp(1900, 2, 28, 24, 0, 0);          // century, not a leap year
    send_stamp(2024, 2, 29, 24, 0, 0);
    send_stamp(2023, 2, 29, 0, 0, 0);           // day past month end with no hour carry
    send_stamp(2400, 2, 28, 24, 0, 0);          // divisible by 400
    send_stamp(2100, 2, 28, 48, 0, 0);
    send_stamp(9999, 12, 31, 23, 59, 60);       // new year from one second
    send_stamp(2021, 13, 1, 0, 0, 0);
    send_stamp(2021, 24, 31, 0, 0, 0);
    send_stamp(2021, 25, 0, 0, 0, 0);
    send_stamp(16383, 13, 1, 0, 0, 0);          // year wraps at 14 bits
    send_stamp(16383, 14, 29, 0, 0, 0);         // leap day in the carried year 16384, which wraps to 0
    send_stamp(2023, 1, 63, 255, 255, 255);
    send_stamp(2023, 4, 30, 24, 0, 0);
    send_stamp(2023, 11, 30, 255, 0, 0);
    send_stamp(5000, 12, 31, 255, 255, 255);
    send_stamp(1, 1, 1, 0, 0, 59);
    send_stamp(0, 63, 0, 0, 255, 0);
    send_stamp(4, 60, 31, 0, 0, 0);

    repeat (N_RANDOM) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        yr = $urandom_range(0, 16383);
        mo = $urandom_range(0, 63);
        dy = $urandom_range(0, 63);
        hr = $urandom_range(0, 255);
        mi = $urandom_range(0, 255);
        se = $urandom_range(0, 255);
      end else if (kind < 8) begin
        // close to month and year boundaries, around leap rules
        case ($urandom_range(0, 2))
          0:       yr = $urandom_range(0, 99) * 100;
          1:       yr = $urandom_range(0, 2499) * 4;
          default: yr = $urandom_range(0, 9999);
        endcase
        mo = $urandom_range(0, 3) == 0 ? $urandom_range(11, 26) : $urandom_range(1, 12);
        dy = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(27, 31);
        hr = $urandom_range(0, 1) ? $urandom_range(20, 30) : $urandom_range(0, 255);
        mi = $urandom_range(0, 1) ? $urandom_range(55, 65) : $urandom_range(0, 255);
        se = $urandom_range(0, 1) ? $urandom_range(55, 65) : $urandom_range(0, 255);
      end else begin
        yr = $urandom_range(0, 9999);
        mo = $urandom_range(1, 12);
        dy = $urandom_range(1, 31);
        hr = $urandom_range(0, 23);
        mi = $urandom_range(0, 59);
        se = $urandom_range(0, 59);
      end
      send_stamp(yr, mo, dy, hr, mi, se);
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (n_pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("datetime_carry_normalizer_unit test passed");
    else
      $display("datetime_carry_normalizer_unit test failed");
    $finish;
  end

endmodule
